/* src/rgb_to_hsv_convert_core_assert.svh */
// Assertion macros for the checker file.
`ifndef RGB_TO_HSV_CONVERT_CORE_ASSERT_SVH
`define RGB_TO_HSV_CONVERT_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RHC_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rgb_to_hsv_convert_core: assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RHC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rgb_to_hsv_convert_core: assertion failed");

`endif

/* src/rhc_pkg.sv */
package rhc_pkg;

  localparam int CHANNEL_BITS_DEF = 8;
  localparam int HUE_BITS         = 15;
  localparam int HUE_Q_BITS       = 12;

  localparam logic [HUE_BITS-1:0] HUE_SIXTH = 15'd3840;
  localparam logic [HUE_BITS-1:0] HUE_GREEN = 15'd7680;
  localparam logic [HUE_BITS-1:0] HUE_BLUE  = 15'd15360;
  localparam logic [HUE_BITS-1:0] HUE_TURN  = 15'd23040;

  typedef enum logic [1:0] {
    BR_RED,
    BR_GREEN,
    BR_BLUE
  } branch_e;

  typedef struct packed {
    branch_e branch;
    logic    neg;
    logic    grey;
  } ctl_t;

endpackage

/* src/rhc_if.sv */
interface rhc_pix_if #(
  parameter int CHANNEL_BITS = 8
);
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] red;
  logic [CHANNEL_BITS-1:0] green;
  logic [CHANNEL_BITS-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface rhc_hsv_if
  import rhc_pkg::*;
#(
  parameter int CHANNEL_BITS = 8
);
  logic                    valid;
  logic                    ready;
  logic [HUE_BITS-1:0]     hue;
  logic [CHANNEL_BITS-1:0] saturation;
  logic [CHANNEL_BITS-1:0] brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink (input valid, input hue, input saturation, input brightness,
                output ready);
endinterface

/* src/rhc_front.sv */
module rhc_front
  import rhc_pkg::*;
#(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
  parameter int REM_BITS     = CHANNEL_BITS + HUE_Q_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  rhc_pix_if.sink                 pix_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output ctl_t                    ctl_o,
  output logic [CHANNEL_BITS-1:0] mx_o,
  output logic [CHANNEL_BITS-1:0] delta_o,
  output logic [REM_BITS-1:0]     hnum_o,
  output logic [REM_BITS-1:0]     snum_o
);

  localparam logic [REM_BITS-1:0] FULL = REM_BITS'((64'd1 << CHANNEL_BITS) - 64'd1);

  logic [CHANNEL_BITS-1:0] mx, mn, delta, da, db, mag;
  ctl_t                    ctl;
  logic                    load;
  logic                    valid_q;
  ctl_t                    ctl_q;
  logic [CHANNEL_BITS-1:0] mx_q, delta_q;
  logic [REM_BITS-1:0]     hnum_q, snum_q;

  always_comb begin
    mx = pix_i.red;
    mn = pix_i.red;
    if (pix_i.green > mx) mx = pix_i.green;
    if (pix_i.blue > mx) mx = pix_i.blue;
    if (pix_i.green < mn) mn = pix_i.green;
    if (pix_i.blue < mn) mn = pix_i.blue;
    delta = mx - mn;
    if (mx == pix_i.red) begin
      ctl.branch = BR_RED;
      da = pix_i.green;
      db = pix_i.blue;
    end else if (mx == pix_i.green) begin
      ctl.branch = BR_GREEN;
      da = pix_i.blue;
      db = pix_i.red;
    end else begin
      ctl.branch = BR_BLUE;
      da = pix_i.red;
      db = pix_i.green;
    end
    ctl.neg  = (da < db);
    ctl.grey = (delta == '0);
    mag      = ctl.neg ? (db - da) : (da - db);
  end

  assign load        = !valid_q || ready_i;
  assign pix_i.ready = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= pix_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && pix_i.valid) begin
      ctl_q   <= ctl;
      mx_q    <= mx;
      delta_q <= delta;
      hnum_q  <= REM_BITS'(mag) * REM_BITS'(HUE_SIXTH);
      snum_q  <= REM_BITS'(delta) * FULL;
    end
  end

  assign valid_o = valid_q;
  assign ctl_o   = ctl_q;
  assign mx_o    = mx_q;
  assign delta_o = delta_q;
  assign hnum_o  = hnum_q;
  assign snum_o  = snum_q;

endmodule

/* src/rhc_cell.sv */
module rhc_cell
  import rhc_pkg::*;
#(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
  parameter int Q_BITS       = HUE_Q_BITS,
  parameter int REM_BITS     = CHANNEL_BITS + HUE_Q_BITS,
  parameter int BIT_POS      = 0
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  output logic                    valid_o,
  input  logic                    ready_i,
  input  ctl_t                    ctl_i,
  input  logic [CHANNEL_BITS-1:0] mx_i,
  input  logic [CHANNEL_BITS-1:0] delta_i,
  input  logic [REM_BITS-1:0]     hrem_i,
  input  logic [REM_BITS-1:0]     srem_i,
  input  logic [Q_BITS-1:0]       hq_i,
  input  logic [Q_BITS-1:0]       sq_i,
  output ctl_t                    ctl_o,
  output logic [CHANNEL_BITS-1:0] mx_o,
  output logic [CHANNEL_BITS-1:0] delta_o,
  output logic [REM_BITS-1:0]     hrem_o,
  output logic [REM_BITS-1:0]     srem_o,
  output logic [Q_BITS-1:0]       hq_o,
  output logic [Q_BITS-1:0]       sq_o
);

  // Each cell retires one quotient bit of both divisions.
  logic [REM_BITS-1:0]     hdiv, sdiv, hrem_d, srem_d;
  logic [Q_BITS-1:0]       hq_d, sq_d;
  logic                    hge, sge;
  logic                    load;
  logic                    valid_q;
  ctl_t                    ctl_q;
  logic [CHANNEL_BITS-1:0] mx_q, delta_q;
  logic [REM_BITS-1:0]     hrem_q, srem_q;
  logic [Q_BITS-1:0]       hq_q, sq_q;

  always_comb begin
    hdiv   = REM_BITS'(delta_i) << BIT_POS;
    sdiv   = REM_BITS'(mx_i) << BIT_POS;
    hge    = (hrem_i >= hdiv);
    sge    = (srem_i >= sdiv);
    hrem_d = hge ? (hrem_i - hdiv) : hrem_i;
    srem_d = sge ? (srem_i - sdiv) : srem_i;
    hq_d   = hq_i;
    sq_d   = sq_i;
    hq_d[BIT_POS] = hge;
    sq_d[BIT_POS] = sge;
  end

  assign load    = !valid_q || ready_i;
  assign ready_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && valid_i) begin
      ctl_q   <= ctl_i;
      mx_q    <= mx_i;
      delta_q <= delta_i;
      hrem_q  <= hrem_d;
      srem_q  <= srem_d;
      hq_q    <= hq_d;
      sq_q    <= sq_d;
    end
  end

  assign valid_o = valid_q;
  assign ctl_o   = ctl_q;
  assign mx_o    = mx_q;
  assign delta_o = delta_q;
  assign hrem_o  = hrem_q;
  assign srem_o  = srem_q;
  assign hq_o    = hq_q;
  assign sq_o    = sq_q;

endmodule

/* src/rhc_back.sv */
module rhc_back
  import rhc_pkg::*;
#(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
  parameter int Q_BITS       = HUE_Q_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  ctl_t                    ctl_i,
  input  logic [CHANNEL_BITS-1:0] mx_i,
  input  logic [Q_BITS-1:0]       hq_i,
  input  logic [Q_BITS-1:0]       sq_i,
  rhc_hsv_if.source               hsv_o
);

  logic [HUE_BITS-1:0]     offset, base, hue_d, hq;
  logic [CHANNEL_BITS-1:0] sat_d;
  logic                    load;
  logic                    valid_q;
  logic [HUE_BITS-1:0]     hue_q;
  logic [CHANNEL_BITS-1:0] sat_q, val_q;

  always_comb begin
    hq = HUE_BITS'(hq_i[HUE_Q_BITS-1:0]);
    case (ctl_i.branch)
      BR_RED:   offset = '0;
      BR_GREEN: offset = HUE_GREEN;
      BR_BLUE:  offset = HUE_BLUE;
      default:  offset = '0;
    endcase
    // A negative red hue wraps into the last sixth of the turn.
    base = (ctl_i.branch == BR_RED) ? HUE_TURN : offset;
    if (ctl_i.grey) begin
      hue_d = '0;
    end else if (ctl_i.neg && (hq != '0)) begin
      hue_d = base - hq;
    end else begin
      hue_d = offset + hq;
    end
    sat_d = ctl_i.grey ? '0 : sq_i[CHANNEL_BITS-1:0];
  end

  assign load    = !valid_q || hsv_o.ready;
  assign ready_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && valid_i) begin
      hue_q <= hue_d;
      sat_q <= sat_d;
      val_q <= mx_i;
    end
  end

  assign hsv_o.valid      = valid_q;
  assign hsv_o.hue        = hue_q;
  assign hsv_o.saturation = sat_q;
  assign hsv_o.brightness = val_q;

endmodule

/* src/rgb_to_hsv_convert_core.sv */
// RGB to HSV pixel converter. Each beat on pix_i carries one pixel as three unsigned
// channels; each beat on hsv_o carries its hue in 1/64 degree (0 to 23039), its
// saturation (full scale means fully saturated) and its value (the largest channel).
// One pixel is accepted per clock unless a stall backs up to the input, and results
// leave in order, one per pixel. A front stage finds the extremes and the scaled
// numerators, then a row of divider cells retires one quotient bit each for hue and
// saturation together, and a back stage folds the hue sector offset into the output
// register. Every stage holds its own beat, so a stalled output only backs up the
// stages behind it. The block keeps no state between pixels.
module rgb_to_hsv_convert_core
  import rhc_pkg::*;
#(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rhc_pix_if.sink   pix_i,
  rhc_hsv_if.source hsv_o
);

  localparam int Q_BITS   = (CHANNEL_BITS > HUE_Q_BITS) ? CHANNEL_BITS : HUE_Q_BITS;
  localparam int REM_BITS = CHANNEL_BITS + Q_BITS;

  logic                    valid_w [Q_BITS+1];
  logic                    ready_w [Q_BITS+1];
  ctl_t                    ctl_w   [Q_BITS+1];
  logic [CHANNEL_BITS-1:0] mx_w    [Q_BITS+1];
  logic [CHANNEL_BITS-1:0] delta_w [Q_BITS+1];
  logic [REM_BITS-1:0]     hrem_w  [Q_BITS+1];
  logic [REM_BITS-1:0]     srem_w  [Q_BITS+1];
  logic [Q_BITS-1:0]       hq_w    [Q_BITS+1];
  logic [Q_BITS-1:0]       sq_w    [Q_BITS+1];

  rhc_front #(
    .CHANNEL_BITS(CHANNEL_BITS),
    .REM_BITS    (REM_BITS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_i),
    .valid_o(valid_w[0]),
    .ready_i(ready_w[0]),
    .ctl_o  (ctl_w[0]),
    .mx_o   (mx_w[0]),
    .delta_o(delta_w[0]),
    .hnum_o (hrem_w[0]),
    .snum_o (srem_w[0])
  );

  assign hq_w[0] = '0;
  assign sq_w[0] = '0;

  for (genvar k = 0; k < Q_BITS; k++) begin : g_cell
    rhc_cell #(
      .CHANNEL_BITS(CHANNEL_BITS),
      .Q_BITS      (Q_BITS),
      .REM_BITS    (REM_BITS),
      .BIT_POS     (Q_BITS - 1 - k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(valid_w[k]),
      .ready_o(ready_w[k]),
      .valid_o(valid_w[k+1]),
      .ready_i(ready_w[k+1]),
      .ctl_i  (ctl_w[k]),
      .mx_i   (mx_w[k]),
      .delta_i(delta_w[k]),
      .hrem_i (hrem_w[k]),
      .srem_i (srem_w[k]),
      .hq_i   (hq_w[k]),
      .sq_i   (sq_w[k]),
      .ctl_o  (ctl_w[k+1]),
      .mx_o   (mx_w[k+1]),
      .delta_o(delta_w[k+1]),
      .hrem_o (hrem_w[k+1]),
      .srem_o (srem_w[k+1]),
      .hq_o   (hq_w[k+1]),
      .sq_o   (sq_w[k+1])
    );
  end

  rhc_back #(
    .CHANNEL_BITS(CHANNEL_BITS),
    .Q_BITS      (Q_BITS)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(valid_w[Q_BITS]),
    .ready_o(ready_w[Q_BITS]),
    .ctl_i  (ctl_w[Q_BITS]),
    .mx_i   (mx_w[Q_BITS]),
    .hq_i   (hq_w[Q_BITS]),
    .sq_i   (sq_w[Q_BITS]),
    .hsv_o  (hsv_o)
  );

endmodule

/* src/rhc_chk.sv */
`include "rgb_to_hsv_convert_core_assert.svh"

module rhc_chk
  import rhc_pkg::*;
#(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    hsv_valid_i,
  input logic                    hsv_ready_i,
  input logic [HUE_BITS-1:0]     hue_i,
  input logic [CHANNEL_BITS-1:0] saturation_i,
  input logic [CHANNEL_BITS-1:0] brightness_i
);

  // A result beat that is not taken stays up and unchanged.
  `RHC_ASSERT_NEXT(a_out_hold, hsv_valid_i && !hsv_ready_i, hsv_valid_i && $stable(hue_i) && $stable(saturation_i) && $stable(brightness_i))

  `RHC_ASSERT_IMPLY(a_hue_range, hsv_valid_i, hue_i < HUE_TURN)

  // A colored pixel always has some saturation, and saturation needs a nonzero value.
  `RHC_ASSERT_IMPLY(a_hue_sat, hsv_valid_i && (hue_i != '0), saturation_i != '0)

  `RHC_ASSERT_IMPLY(a_sat_val, hsv_valid_i && (saturation_i != '0), brightness_i != '0)

endmodule

bind rgb_to_hsv_convert_core rhc_chk #(
  .CHANNEL_BITS(CHANNEL_BITS)
) u_rhc_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .hsv_valid_i (hsv_o.valid),
  .hsv_ready_i (hsv_o.ready),
  .hue_i       (hsv_o.hue),
  .saturation_i(hsv_o.saturation),
  .brightness_i(hsv_o.brightness)
);

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import rhc_pkg::*;

  localparam int CB         = CHANNEL_BITS_DEF;
  localparam int FULL_SCALE = (1 << CB) - 1;
  localparam int RAND_BEATS = 1300;
  localparam int CALM_AFTER = 1100;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_WAIT = 30;

  typedef struct packed {
    logic [HUE_BITS-1:0] hue;
    logic [CB-1:0]       saturation;
    logic [CB-1:0]       brightness;
  } hsv_t;

  class hsv_scoreboard;
    hsv_t expected_q[$];
    int   failures;

    function new();
      failures = 0;
    endfunction

    function hsv_t predict_hsv(logic [CB-1:0] r, logic [CB-1:0] g, logic [CB-1:0] b);
      hsv_t    res;
      int      rv;
      int      gv;
      int      bv;
      int      mx;
      int      mn;
      int      delta;
      int      hue;
      branch_e sector;
      rv = int'(r);
      gv = int'(g);
      bv = int'(b);
      if (rv >= gv && rv >= bv) begin
        sector = BR_RED;
        mx     = rv;
      end else if (gv >= bv) begin
        sector = BR_GREEN;
        mx     = gv;
      end else begin
        sector = BR_BLUE;
        mx     = bv;
      end
      mn = rv;
      if (gv < mn) mn = gv;
      if (bv < mn) mn = bv;
      delta = mx - mn;
      hue = 0;
      if (delta != 0) begin
        case (sector)
          BR_RED: begin
            hue = (int'(HUE_SIXTH) * (gv - bv)) / delta;
          end
          BR_GREEN: begin
            hue = (int'(HUE_SIXTH) * (bv - rv)) / delta + int'(HUE_GREEN);
          end
          default: begin
            hue = (int'(HUE_SIXTH) * (rv - gv)) / delta + int'(HUE_BLUE);
          end
        endcase
      end
      if (hue < 0) hue += int'(HUE_TURN);
      res.hue        = hue[HUE_BITS-1:0];
      res.saturation = (mx == 0) ? '0 : CB'((FULL_SCALE * delta) / mx);
      res.brightness = CB'(mx);
      return res;
    endfunction

    function void note_pixel(logic [CB-1:0] r, logic [CB-1:0] g, logic [CB-1:0] b);
      expected_q.push_back(predict_hsv(r, g, b));
    endfunction

    function void check_result(logic [HUE_BITS-1:0] hue, logic [CB-1:0] sat,
                               logic [CB-1:0] bri);
      hsv_t want;
      if (expected_q.size() == 0) begin
        $error("result beat with no pixel outstanding: hue %0d sat %0d val %0d",
               hue, sat, bri);
        failures++;
        return;
      end
      want = expected_q.pop_front();
      if (hue !== want.hue) begin
        $error("hue: expected %0d, actual %0d", want.hue, hue);
        failures++;
      end
      if (sat !== want.saturation) begin
        $error("saturation: expected %0d, actual %0d", want.saturation, sat);
        failures++;
      end
      if (bri !== want.brightness) begin
        $error("brightness: expected %0d, actual %0d", want.brightness, bri);
        failures++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic calm  = 1'b0;

  hsv_scoreboard sb = new();

  rhc_pix_if #(.CHANNEL_BITS(CB)) pix ();
  rhc_hsv_if #(.CHANNEL_BITS(CB)) hsv ();

  rgb_to_hsv_convert_core #(
    .CHANNEL_BITS(CB)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .pix_i (pix),
    .hsv_o (hsv)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && pix.valid && pix.ready) sb.note_pixel(pix.red, pix.green, pix.blue);
  end

  always @(posedge clk) begin
    if (rst_n && hsv.valid && hsv.ready) begin
      sb.check_result(hsv.hue, hsv.saturation, hsv.brightness);
    end
  end

  initial begin
    int stall;
    stall = 0;
    hsv.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!calm && stall == 0 && $urandom_range(0, 7) == 0) stall = $urandom_range(1, 18);
      if (stall > 0) begin
        hsv.ready <= 1'b0;
        stall--;
      end else begin
        hsv.ready <= 1'b1;
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    @(posedge rst_n);
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((pix.valid && pix.ready) || (hsv.valid && hsv.ready)) idle = 0;
      else idle++;
    end
    $display("rgb_to_hsv_convert_core: mismatch");
    $finish;
  end

  task automatic send_pixel(input logic [CB-1:0] r, input logic [CB-1:0] g,
                            input logic [CB-1:0] b);
    int gap;
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 18);
      pix.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix.valid <= 1'b1;
    pix.red   <= r;
    pix.green <= g;
    pix.blue  <= b;
    do @(posedge clk); while (!pix.ready);
    @(negedge clk);
  endtask

  task automatic send_random_pixel();
    logic [CB-1:0] r;
    logic [CB-1:0] g;
    logic [CB-1:0] b;
    logic [CB-1:0] hi;
    logic [CB-1:0] lo;
    r = CB'($urandom);
    g = CB'($urandom);
    b = CB'($urandom);
    case ($urandom_range(0, 9))
      5: begin
        g = r;
        b = r;
      end
      6: begin
        hi = CB'($urandom_range(1, FULL_SCALE));
        lo = CB'($urandom_range(0, int'(hi) - 1));
        case ($urandom_range(0, 2))
          0: begin r = hi; g = hi; b = lo; end
          1: begin r = lo; g = hi; b = hi; end
          default: begin r = hi; g = lo; b = hi; end
        endcase
      end
      7: begin
        hi = CB'($urandom_range(3, FULL_SCALE));
        r  = hi - CB'($urandom_range(0, 3));
        g  = hi - CB'($urandom_range(0, 3));
        b  = hi - CB'($urandom_range(0, 3));
      end
      8: begin
        case ($urandom_range(0, 2))
          0: r = $urandom_range(0, 1) ? '1 : '0;
          1: g = $urandom_range(0, 1) ? '1 : '0;
          default: b = $urandom_range(0, 1) ? '1 : '0;
        endcase
      end
      9: begin
        r = $urandom_range(0, 1) ? '1 : '0;
        g = $urandom_range(0, 1) ? '1 : '0;
        b = $urandom_range(0, 1) ? '1 : '0;
      end
      default: begin
      end
    endcase
    send_pixel(r, g, b);
  endtask

  initial begin
    pix.valid <= 1'b0;
    pix.red   <= '0;
    pix.green <= '0;
    pix.blue  <= '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Black, white and greys, each pure primary, every two-way tie, then near ties and mixed colours.
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd1, 8'd1, 8'd1);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd1, 8'd0);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd1);
    send_pixel(8'd254, 8'd255, 8'd0);
    send_pixel(8'd255, 8'd254, 8'd255);
    send_pixel(8'd1, 8'd0, 8'd255);
    send_pixel(8'd128, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd128, 8'd0);
    send_pixel(8'd17, 8'd200, 8'd93);
    send_pixel(8'd170, 8'd85, 8'd1);

    for (int i = 0; i < RAND_BEATS; i++) begin
      if (i == CALM_AFTER) calm = 1'b1;
      send_random_pixel();
    end
    pix.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.failures == 0) begin
      $display("rgb_to_hsv_convert_core: match");
    end else begin
      $display("rgb_to_hsv_convert_core: mismatch");
    end
    $finish;
  end

endmodule
